[src/double_ended_priority_queue_core_defines.svh]
// Assertion macros used by the checker file of the priority queue core.
// No dependencies; take in by `include with the bare file name.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define DEPQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("depq assertion failed");

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define DEPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("depq assertion failed");

`endif

[src/depq_pkg.sv]
// Shared types, codes and constants of the double-ended priority queue core.
// No dependencies.
package depq_pkg;

  localparam int CapacityDef = 256;
  localparam int ClientW     = 20;
  localparam int PrioW       = 24;
  localparam int OpW         = 2;

  localparam logic [OpW-1:0] OpInsert    = 2'd0;
  localparam logic [OpW-1:0] OpServeHigh = 2'd1;
  localparam logic [OpW-1:0] OpServeLow  = 2'd2;

  typedef enum logic [1:0] {
    CmdHold      = 2'd0,
    CmdInsert    = 2'd1,
    CmdShiftDown = 2'd2,
    CmdDropTop   = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [PrioW-1:0]   prio;
    logic [ClientW-1:0] client;
  } cell_ctl_t;

  // Radix-4 reduction levels needed to cover n leaves.
  function automatic int tree_levels(input int n);
    int l;
    l = ($clog2(n) + 1) / 2;
    return (l < 1) ? 1 : l;
  endfunction

endpackage

[src/double_ended_priority_queue_core.sv]
// Double-ended priority queue: a chain of CAPACITY sorted cells, lowest at cell 0.
// Insert and serve-lowest register their result at the accepting edge.
// Serve-highest waits for the registered OR tree of L = ceil(log4(CAPACITY))
// levels (4 at 256) that picks the top cell to settle before the entry drops.
// Throughput: one transaction per cycle for insert/serve-lowest while results are taken; serve-highest blocks new ones.
// Reset (rst_ni low, asynchronous) empties the chain and the output register.
module double_ended_priority_queue_core #(
  parameter int CAPACITY = depq_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [depq_pkg::OpW-1:0]      op_i,
  input  logic [depq_pkg::ClientW-1:0]  client_id_i,
  input  logic [depq_pkg::PrioW-1:0]    priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [depq_pkg::ClientW-1:0]  served_client_o,
  output logic                          was_empty_o,
  output logic                          insert_dropped_o
);

  localparam int CountW     = $clog2(CAPACITY + 1);
  localparam int TreeLevels = depq_pkg::tree_levels(CAPACITY);
  localparam int WaitW      = (TreeLevels > 1) ? $clog2(TreeLevels) : 1;

  // One-hot controller states.
  typedef enum logic [1:0] {
    StIdle    = 2'b01,
    StWaitTop = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [WaitW-1:0]             wait_q, wait_d;
  logic [CountW-1:0]            count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  logic [depq_pkg::ClientW-1:0] served_q, served_d;
  logic                         empty_q, empty_d;
  logic                         dropped_q, dropped_d;

  depq_pkg::cell_ctl_t          cell_ctl;
  logic                         accept, out_take, is_empty, is_full;

  // Chain wiring: one slot per cell.
  logic                                cell_valid [CAPACITY];
  logic                                cell_keep  [CAPACITY];
  logic [depq_pkg::PrioW-1:0]          cell_prio  [CAPACITY];
  logic [depq_pkg::ClientW-1:0]        cell_client[CAPACITY];
  logic [CAPACITY-1:0][depq_pkg::ClientW-1:0] top_client;
  logic [depq_pkg::ClientW-1:0]        tree_client;

  assign accept   = in_valid_i && in_ready_o;
  assign out_take = out_valid_q && out_ready_i;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CountW'(CAPACITY));

  // Take a new transaction only when idle and the result slot frees this cycle.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d         = state_q;
    wait_d          = wait_q;
    count_d         = count_q;
    out_valid_d     = out_valid_q && !out_take;
    served_d        = served_q;
    empty_d         = empty_q;
    dropped_d       = dropped_q;
    cell_ctl.cmd    = depq_pkg::CmdHold;
    cell_ctl.prio   = priority_req_i;
    cell_ctl.client = client_id_i;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (op_i)
            depq_pkg::OpInsert: begin
              // Drop the insert when full, otherwise slot it in.
              out_valid_d = 1'b1;
              served_d    = '0;
              empty_d     = 1'b0;
              dropped_d   = is_full;
              if (!is_full) begin
                cell_ctl.cmd = depq_pkg::CmdInsert;
                count_d      = count_q + CountW'(1);
              end
            end
            depq_pkg::OpServeHigh: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                served_d    = '0;
                empty_d     = 1'b1;
                dropped_d   = 1'b0;
              end else begin
                // Hold the chain while the top-cell tree settles.
                state_d = StWaitTop;
                wait_d  = WaitW'(TreeLevels - 1);
              end
            end
            depq_pkg::OpServeLow: begin
              out_valid_d = 1'b1;
              empty_d     = is_empty;
              dropped_d   = 1'b0;
              served_d    = is_empty ? '0 : cell_client[0];
              if (!is_empty) begin
                cell_ctl.cmd = depq_pkg::CmdShiftDown;
                count_d      = count_q - CountW'(1);
              end
            end
            default: begin
              out_valid_d = 1'b1;
              served_d    = '0;
              empty_d     = 1'b0;
              dropped_d   = 1'b0;
            end
          endcase
        end
      end
      StWaitTop: begin
        if (wait_q == '0) begin
          // Tree output is now the top cell's client: drop that cell.
          cell_ctl.cmd = depq_pkg::CmdDropTop;
          count_d      = count_q - CountW'(1);
          out_valid_d  = 1'b1;
          served_d     = tree_client;
          empty_d      = 1'b0;
          dropped_d    = 1'b0;
          state_d      = StIdle;
        end else begin
          wait_d = wait_q - WaitW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wait_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_q  <= served_d;
    empty_q   <= empty_d;
    dropped_q <= dropped_d;
  end

  assign out_valid_o      = out_valid_q;
  assign served_client_o  = served_q;
  assign was_empty_o      = empty_q;
  assign insert_dropped_o = dropped_q;

  // The chain: every cell sees its two neighbours; the ends see empty space.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         l_keep, l_valid, r_valid;
    logic [depq_pkg::PrioW-1:0]   l_prio, r_prio;
    logic [depq_pkg::ClientW-1:0] l_client, r_client;

    if (i == 0) begin : g_low_end
      assign l_keep   = 1'b1;
      assign l_valid  = 1'b0;
      assign l_prio   = '0;
      assign l_client = '0;
    end else begin : g_low_link
      assign l_keep   = cell_keep[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_prio   = cell_prio[i-1];
      assign l_client = cell_client[i-1];
    end

    if (i == CAPACITY - 1) begin : g_high_end
      assign r_valid  = 1'b0;
      assign r_prio   = '0;
      assign r_client = '0;
    end else begin : g_high_link
      assign r_valid  = cell_valid[i+1];
      assign r_prio   = cell_prio[i+1];
      assign r_client = cell_client[i+1];
    end

    depq_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctl_i          (cell_ctl),
      .left_keep_i    (l_keep),
      .left_valid_i   (l_valid),
      .left_prio_i    (l_prio),
      .left_client_i  (l_client),
      .right_valid_i  (r_valid),
      .right_prio_i   (r_prio),
      .right_client_i (r_client),
      .valid_o        (cell_valid[i]),
      .keep_o         (cell_keep[i]),
      .prio_o         (cell_prio[i]),
      .client_o       (cell_client[i]),
      .top_client_o   (top_client[i])
    );
  end

  // Only the highest valid cell drives a non-zero leaf.
  depq_or_tree #(
    .N (CAPACITY),
    .W (depq_pkg::ClientW)
  ) u_top_tree (
    .clk_i    (clk_i),
    .leaves_i (top_client),
    .result_o (tree_client)
  );

endmodule

[src/depq_cell.sv]
// One storage cell of the sorted chain: holds one entry and its valid bit.
// Depends on depq_pkg.
module depq_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  depq_pkg::cell_ctl_t         ctl_i,
  input  logic                        left_keep_i,
  input  logic                        left_valid_i,
  input  logic [depq_pkg::PrioW-1:0]   left_prio_i,
  input  logic [depq_pkg::ClientW-1:0] left_client_i,
  input  logic                        right_valid_i,
  input  logic [depq_pkg::PrioW-1:0]   right_prio_i,
  input  logic [depq_pkg::ClientW-1:0] right_client_i,
  output logic                        valid_o,
  output logic                        keep_o,
  output logic [depq_pkg::PrioW-1:0]   prio_o,
  output logic [depq_pkg::ClientW-1:0] client_o,
  output logic [depq_pkg::ClientW-1:0] top_client_o
);

  logic                         valid_q, valid_d;
  logic [depq_pkg::PrioW-1:0]   prio_q, prio_d;
  logic [depq_pkg::ClientW-1:0] client_q, client_d;
  logic                         keep;

  // Strictly lower entries stay put; the new one lands below equal keys.
  assign keep = valid_q && (prio_q < ctl_i.prio);

  always_comb begin
    valid_d  = valid_q;
    prio_d   = prio_q;
    client_d = client_q;
    case (ctl_i.cmd)
      depq_pkg::CmdInsert: begin
        if (left_keep_i) begin
          if (!keep) begin
            valid_d  = 1'b1;
            prio_d   = ctl_i.prio;
            client_d = ctl_i.client;
          end
        end else begin
          valid_d  = left_valid_i;
          prio_d   = left_prio_i;
          client_d = left_client_i;
        end
      end
      depq_pkg::CmdShiftDown: begin
        valid_d  = right_valid_i;
        prio_d   = right_prio_i;
        client_d = right_client_i;
      end
      depq_pkg::CmdDropTop: begin
        valid_d = valid_q & right_valid_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q   <= prio_d;
    client_q <= client_d;
  end

  assign valid_o      = valid_q;
  assign keep_o       = keep;
  assign prio_o       = prio_q;
  assign client_o     = client_q;
  assign top_client_o = (valid_q && !right_valid_i) ? client_q : '0;

endmodule

[src/depq_or_tree.sv]
// Registered radix-4 OR reduction over one-hot masked leaves.
// Depends on depq_pkg for the level count.
module depq_or_tree #(
  parameter int N = depq_pkg::CapacityDef,
  parameter int W = depq_pkg::ClientW
) (
  input  logic                clk_i,
  input  logic [N-1:0][W-1:0] leaves_i,
  output logic [W-1:0]        result_o
);

  localparam int Levels = depq_pkg::tree_levels(N);
  localparam int PadN   = 1 << (2 * Levels);
  localparam int Nodes  = PadN / 4;

  logic [W-1:0] leaf [PadN];
  logic [W-1:0] node_q [Levels][Nodes];

  always_comb begin
    for (int j = 0; j < PadN; j++) begin
      leaf[j] = (j < N) ? leaves_i[j] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Nodes; j++) begin
      node_q[0][j] <= leaf[4*j] | leaf[4*j+1] | leaf[4*j+2] | leaf[4*j+3];
    end
    for (int k = 1; k < Levels; k++) begin
      for (int j = 0; j < Nodes; j++) begin
        if (j < (PadN >> (2 * (k + 1)))) begin
          node_q[k][j] <= node_q[k-1][4*j] | node_q[k-1][4*j+1] |
                          node_q[k-1][4*j+2] | node_q[k-1][4*j+3];
        end else begin
          node_q[k][j] <= '0;
        end
      end
    end
  end

  assign result_o = node_q[Levels-1][0];

endmodule

[src/depq_checker.sv]
// Port-level checker for the double-ended priority queue core, with its bind.
// Depends on depq_pkg and double_ended_priority_queue_core_defines.svh.
`include "double_ended_priority_queue_core_defines.svh"

module depq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [depq_pkg::OpW-1:0]      op_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [depq_pkg::ClientW-1:0]  served_client_o,
  input logic                          was_empty_o,
  input logic                          insert_dropped_o
);

  // A pending result holds until taken.
  `DEPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // Empty and dropped never flag together.
  `DEPQ_ASSERT_NOW(a_flags_excl, clk_i, rst_ni, out_valid_o, !(was_empty_o && insert_dropped_o))

  // An empty serve returns no client.
  `DEPQ_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_o && was_empty_o, served_client_o == '0)

  // A dropped insert returns no client.
  `DEPQ_ASSERT_NOW(a_drop_zero, clk_i, rst_ni, out_valid_o && insert_dropped_o,
                   served_client_o == '0)

  // An accepted insert yields a result on the next cycle.
  `DEPQ_ASSERT_NEXT(a_insert_result, clk_i, rst_ni,
                    in_valid_i && in_ready_o && (op_i == depq_pkg::OpInsert), out_valid_o)

endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (.*);
